### rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared constants, codes and types for the protection switch capacity core.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int NUM_COMPONENTS = 32;
  localparam int MASK_W         = 32;
  localparam int BW_W           = 24;
  localparam int LIM_IDX_W      = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_MASK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROTECTION_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEMAND_BW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_INDEX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_VALUE     = 3'd4;

  localparam logic [1:0] PS_PRIMARY   = 2'd0;
  localparam logic [1:0] PS_SECONDARY = 2'd1;
  localparam logic [1:0] PS_FAIL      = 2'd2;

  typedef struct packed {
    logic tok;
    logic blk;
  } chain_t;

  typedef struct packed {
    logic reserve;
    logic rel;
  } cell_op_t;

endpackage

### rtl/psc_cell.sv
// ----------------------------------------------------------------------------
// psc_cell
// One component: reserved bandwidth and limit, capacity test on token pass.
// ----------------------------------------------------------------------------
module psc_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        on_backup,
  input  logic [psc_pkg::BW_W-1:0]    demand,
  input  psc_pkg::cell_op_t           op,
  input  logic                        lim_we,
  input  logic [psc_pkg::BW_W-1:0]    lim_val,
  input  psc_pkg::chain_t             chain_in,
  output psc_pkg::chain_t             chain_out
);

  logic [psc_pkg::BW_W-1:0] reserved;
  logic [psc_pkg::BW_W-1:0] limit;
  logic [psc_pkg::BW_W-1:0] reserved_next;
  logic [psc_pkg::BW_W:0]   sum;
  logic                     over;

  assign sum  = {1'b0, reserved} + {1'b0, demand};
  assign over = on_backup && (reserved > limit);

  always_comb begin
    reserved_next = reserved;
    if (on_backup && op.reserve) begin
      reserved_next = sum[psc_pkg::BW_W] ? {psc_pkg::BW_W{1'b1}} : sum[psc_pkg::BW_W-1:0];
    end else if (on_backup && op.rel) begin
      reserved_next = (reserved > demand) ? (reserved - demand) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved      <= '0;
      limit         <= '0;
      chain_out.tok <= 1'b0;
      chain_out.blk <= 1'b0;
    end else begin
      reserved      <= reserved_next;
      if (lim_we) begin
        limit <= lim_val;
      end
      chain_out.tok <= chain_in.tok;
      chain_out.blk <= chain_in.blk | (chain_in.tok & over);
    end
  end

endmodule

### rtl/psc_ctrl.sv
// ----------------------------------------------------------------------------
// psc_ctrl
// Path state machine: launches the capacity sweep, applies the transition
// and holds the result register.
// ----------------------------------------------------------------------------
module psc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [psc_pkg::MASK_W-1:0]    failed_mask,
  input  logic                          last_event,
  input  logic [psc_pkg::MASK_W-1:0]    primary_mask,
  input  logic [psc_pkg::MASK_W-1:0]    protection_mask,
  output logic                          tok_start,
  input  psc_pkg::chain_t               chain_end,
  output psc_pkg::cell_op_t             op,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    path_state_out,
  output logic                          capacity_blocked,
  output logic                          run_done
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] path_state;
  logic [1:0] path_state_next;
  logic       wd;
  logic       bd;
  logic       last;
  logic       blk;
  logic       wd_in;
  logic       bd_in;
  logic       accept;
  logic       slot_free;
  logic       finish;
  logic       need_check;

  assign wd_in     = |(failed_mask & primary_mask);
  assign bd_in     = |(failed_mask & protection_mask);
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign finish    = (state == S_DONE) && slot_free;

  always_comb begin
    need_check = 1'b0;
    case (path_state)
      psc_pkg::PS_PRIMARY: need_check = wd_in && !bd_in;
      psc_pkg::PS_FAIL:    need_check = wd_in;
      default:             need_check = 1'b0;
    endcase
  end

  assign tok_start = accept && need_check;

  always_comb begin
    path_state_next = path_state;
    op              = '0;
    case (path_state)
      psc_pkg::PS_PRIMARY: begin
        if (wd) begin
          if (bd || blk) begin
            path_state_next = psc_pkg::PS_FAIL;
          end else begin
            op.reserve      = 1'b1;
            path_state_next = psc_pkg::PS_SECONDARY;
          end
        end
      end
      psc_pkg::PS_SECONDARY: begin
        if (!wd) begin
          op.rel          = 1'b1;
          path_state_next = psc_pkg::PS_PRIMARY;
        end else if (bd) begin
          op.rel          = 1'b1;
          path_state_next = psc_pkg::PS_FAIL;
        end
      end
      psc_pkg::PS_FAIL: begin
        if (!wd) begin
          path_state_next = psc_pkg::PS_PRIMARY;
        end else if (!bd && !blk) begin
          op.reserve      = 1'b1;
          path_state_next = psc_pkg::PS_SECONDARY;
        end
      end
      default: begin
        path_state_next = psc_pkg::PS_PRIMARY;
      end
    endcase
    if (!finish) begin
      op              = '0;
      path_state_next = path_state;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = need_check ? S_CHECK : S_DONE;
        end
      end
      S_CHECK: begin
        if (chain_end.tok) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      path_state <= psc_pkg::PS_PRIMARY;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      path_state <= path_state_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wd   <= wd_in;
      bd   <= bd_in;
      last <= last_event;
      blk  <= 1'b0;
    end else if (state == S_CHECK && chain_end.tok) begin
      blk <= chain_end.blk;
    end
    if (finish) begin
      path_state_out   <= path_state_next;
      capacity_blocked <= blk;
      run_done         <= last;
    end
  end

  a_tok_in_check: assert property (@(posedge clk) disable iff (rst)
    chain_end.tok |-> state == S_CHECK)
    else $error("sweep token arrived outside check");

  a_op_excl: assert property (@(posedge clk) disable iff (rst)
    !(op.reserve && op.rel))
    else $error("reserve and release issued together");

  a_reserve_sec: assert property (@(posedge clk) disable iff (rst)
    op.reserve |=> path_state == psc_pkg::PS_SECONDARY)
    else $error("reservation without switch to secondary");

  a_blocked_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && capacity_blocked |-> path_state_out == psc_pkg::PS_FAIL)
    else $error("blocked result not in fail");

endmodule

### rtl/protection_switch_capacity_fsm_core.sv
// ----------------------------------------------------------------------------
// protection_switch_capacity_fsm_core
// Shared backup path protection switching with per-component backup
// capacity check over a chain of component cells.
// ----------------------------------------------------------------------------
// Flow: accept, then when a capacity check runs the token walks the chain one
//   cell per cycle, then the result register loads once the output slot is free.
// Events: one at a time; the next accept can come in the cycle after the result
//   register loads.
// Reset: path state primary; reservations, limits, config registers, sweep chain and out_valid zero.
// ----------------------------------------------------------------------------
module protection_switch_capacity_fsm_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [psc_pkg::MASK_W-1:0]       failed_mask,
  input  logic                             last_event,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       path_state_out,
  output logic                             capacity_blocked,
  output logic                             run_done,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [psc_pkg::MASK_W-1:0]    primary_mask;
  logic [psc_pkg::MASK_W-1:0]    protection_mask;
  logic [psc_pkg::BW_W-1:0]      demand_bw;
  logic [psc_pkg::LIM_IDX_W-1:0] limit_index;
  logic                          cfg_wr;
  logic                          lim_wr;
  logic                          tok_start;
  psc_pkg::cell_op_t             op;
  psc_pkg::chain_t               chain [psc_pkg::NUM_COMPONENTS+1];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign lim_wr    = cfg_wr && (cfg_index == psc_pkg::REG_LIMIT_VALUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      primary_mask    <= '0;
      protection_mask <= '0;
      demand_bw       <= '0;
      limit_index     <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        psc_pkg::REG_PRIMARY_MASK:    primary_mask    <= cfg_data;
        psc_pkg::REG_PROTECTION_MASK: protection_mask <= cfg_data;
        psc_pkg::REG_DEMAND_BW:       demand_bw       <= cfg_data[psc_pkg::BW_W-1:0];
        psc_pkg::REG_LIMIT_INDEX:     limit_index     <= cfg_data[psc_pkg::LIM_IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign chain[0].tok = tok_start;
  assign chain[0].blk = 1'b0;

  for (genvar i = 0; i < psc_pkg::NUM_COMPONENTS; i++) begin : g_cell
    logic on_backup;
    logic lim_we;
    if (i < psc_pkg::MASK_W) begin : g_mapped
      assign on_backup = protection_mask[i];
      assign lim_we    = lim_wr && (limit_index == psc_pkg::LIM_IDX_W'(i));
    end else begin : g_unmapped
      assign on_backup = 1'b0;
      assign lim_we    = 1'b0;
    end
    psc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .on_backup (on_backup),
      .demand    (demand_bw),
      .op        (op),
      .lim_we    (lim_we),
      .lim_val   (cfg_data[psc_pkg::BW_W-1:0]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  psc_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .failed_mask      (failed_mask),
    .last_event       (last_event),
    .primary_mask     (primary_mask),
    .protection_mask  (protection_mask),
    .tok_start        (tok_start),
    .chain_end        (chain[psc_pkg::NUM_COMPONENTS]),
    .op               (op),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .path_state_out   (path_state_out),
    .capacity_blocked (capacity_blocked),
    .run_done         (run_done)
  );

endmodule
